// ===== hdl/srts_pkg.sv =====
package srts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int BND_W       = IDX_W + 2;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = VAL_W + IDX_W;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_BINARY = 2'd1;
    localparam logic [1:0] MODE_INTERP = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [9:0]              entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] search_key;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [9:0] position;
    } rsp_t;

endpackage

// ===== hdl/sorted_table_search_top.sv =====
// channel  | signals                      | moves
// req      | req_valid req_ready req      | table write or key search
// rsp      | rsp_valid rsp_ready rsp      | found flag and position
// cfg      | cfg_we cfg_index cfg_wdata   | search_mode, entry_count
// a write request gives no response
// linear search makes one table read per cycle on the ram port, over the first entry_count entries
// binary search reads one entry per probe, in S_BIN_PROBE and then S_BIN_WAIT
// interpolation reads both end values, then divides with the iterative divider unless they match
// reset clears control and config; table contents are undefined until written
// one request at a time; a waiting response stalls only the end of the next search
module sorted_table_search_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  srts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output srts_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [10:0]    cfg_wdata
);
    import srts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LIN, S_BIN_PROBE, S_BIN_WAIT, S_INT_LO, S_INT_HI, S_INT_CHK,
        S_INT_MUL, S_INT_DIV, S_INT_WAIT, S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [1:0]              mode_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [VAL_W-1:0] key_reg;
    logic signed [BND_W-1:0] lo_reg;
    logic signed [BND_W-1:0] hi_reg;
    logic [IDX_W-1:0]        mid_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    pend_reg;
    logic [IDX_W-1:0]        pidx_reg;
    logic signed [VAL_W-1:0] vlo_reg;
    logic [VAL_W-1:0]        num_reg;
    logic [VAL_W-1:0]        den_reg;
    logic [IDX_W-1:0]        span_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    div_start_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;

    logic [CNT_W-1:0]        n_sat;
    logic                    accept;
    logic                    ram_we;
    logic [IDX_W-1:0]        raddr;
    logic [VAL_W-1:0]        rdata_raw;
    logic signed [VAL_W-1:0] rdata;
    logic signed [BND_W-1:0] bin_mid;
    logic                    div_done;
    logic [IDX_W-1:0]        div_q;
    logic                    rsp_free;

    assign n_sat    = (count_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_reg;
    assign req_ready = (state_reg == S_IDLE);
    assign accept   = req_valid && req_ready;
    assign ram_we   = accept && (req.req_type == REQ_WRITE);
    assign rdata    = $signed(rdata_raw);
    assign bin_mid  = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        case (state_reg)
            S_LIN:       raddr = idx_reg[IDX_W-1:0];
            S_BIN_PROBE: raddr = bin_mid[IDX_W-1:0];
            S_INT_LO:    raddr = lo_reg[IDX_W-1:0];
            S_INT_HI:    raddr = hi_reg[IDX_W-1:0];
            S_INT_CHK:   raddr = lo_reg[IDX_W-1:0];
            S_INT_DIV:   raddr = lo_reg[IDX_W-1:0] + div_q;
            default:     raddr = '0;
        endcase
    end

    srts_ram #(
        .WIDTH(VAL_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(req.entry_index),
        .wdata(req.entry_value),
        .raddr(raddr),
        .rdata(rdata_raw)
    );

    srts_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start_reg),
        .dividend(prod_reg),
        .divisor (den_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_LINEAR;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && state_reg != S_FINISH)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_wdata[1:0];
                    CFG_COUNT: count_reg <= cfg_wdata;
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && req.req_type == REQ_SEARCH)
                    begin
                        key_reg   <= req.search_key;
                        lo_reg    <= '0;
                        hi_reg    <= $signed({1'b0, n_sat}) - BND_W'(1);
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        case (mode_reg)
                            MODE_LINEAR: state_reg <= S_LIN;
                            MODE_BINARY: state_reg <= S_BIN_PROBE;
                            MODE_INTERP: state_reg <= S_INT_LO;
                            default:     state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_LIN:
                begin
                    if (pend_reg && rdata == key_reg)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= pidx_reg;
                    end
                    if (idx_reg < n_sat)
                    begin
                        pend_reg <= 1'b1;
                        pidx_reg <= idx_reg[IDX_W-1:0];
                        idx_reg  <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_BIN_PROBE:
                begin
                    if (lo_reg > hi_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        mid_reg   <= bin_mid[IDX_W-1:0];
                        state_reg <= S_BIN_WAIT;
                    end
                end
                S_BIN_WAIT, S_INT_WAIT:
                begin
                    if (rdata == key_reg)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= mid_reg;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        if (rdata < key_reg)
                        begin
                            lo_reg <= $signed({2'b00, mid_reg}) + BND_W'(1);
                        end
                        else
                        begin
                            hi_reg <= $signed({2'b00, mid_reg}) - BND_W'(1);
                        end
                        state_reg <= (state_reg == S_BIN_WAIT) ? S_BIN_PROBE : S_INT_LO;
                    end
                end
                S_INT_LO:
                begin
                    state_reg <= (lo_reg > hi_reg) ? S_FINISH : S_INT_HI;
                end
                S_INT_HI:
                begin
                    vlo_reg   <= rdata;
                    state_reg <= S_INT_CHK;
                end
                S_INT_CHK:
                begin
                    // rdata holds the high end value here
                    if (key_reg < vlo_reg || key_reg > rdata)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (rdata == vlo_reg)
                    begin
                        mid_reg   <= lo_reg[IDX_W-1:0];
                        state_reg <= S_INT_WAIT;
                    end
                    else
                    begin
                        num_reg   <= VAL_W'(key_reg - vlo_reg);
                        den_reg   <= VAL_W'(rdata - vlo_reg);
                        span_reg  <= IDX_W'(hi_reg - lo_reg);
                        state_reg <= S_INT_MUL;
                    end
                end
                S_INT_MUL:
                begin
                    prod_reg      <= num_reg * span_reg;
                    div_start_reg <= 1'b1;
                    state_reg     <= S_INT_DIV;
                end
                S_INT_DIV:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        mid_reg   <= lo_reg[IDX_W-1:0] + div_q;
                        state_reg <= S_INT_WAIT;
                    end
                end
                S_FINISH:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.found    <= found_reg;
                        rsp_reg.position <= found_reg ? pos_reg : '0;
                        rsp_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/srts_ram.sv =====
module srts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/srts_div.sv =====
module srts_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [srts_pkg::PROD_W-1:0]  dividend,
    input  logic [srts_pkg::VAL_W-1:0]   divisor,
    output logic                         done,
    output logic [srts_pkg::IDX_W-1:0]   quotient
);
    import srts_pkg::*;

    localparam int STEP_W = $clog2(IDX_W + 1);

    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  rem_next;
    logic [IDX_W-1:0]  low_reg;
    logic [IDX_W-1:0]  low_next;
    logic [VAL_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    shifted;

    // quotient fits in IDX_W bits, so only the low bits need to be worked
    always_comb
    begin
        shifted = {rem_reg, low_reg[IDX_W-1]};
        trial   = shifted - {1'b0, den_reg};
        if (!trial[VAL_W])
        begin
            rem_next = trial[VAL_W-1:0];
            low_next = {low_reg[IDX_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[VAL_W-1:0];
            low_next = {low_reg[IDX_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(IDX_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:IDX_W];
            low_reg <= dividend[IDX_W-1:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== sim/tb_sorted_table_search_top.sv =====
`timescale 1ns / 1ps

class search_scoreboard;
    logic signed [31:0] table_q [1024];
    logic [1:0]         mode;
    int unsigned        count;
    srts_pkg::rsp_t     expected_q[$];
    int                 mismatches;
    int                 searches;

    function new();
        mode = srts_pkg::MODE_LINEAR;
        count = 0;
        mismatches = 0;
        searches = 0;
    endfunction

    function longint entry(longint i);
        longint v;
        v = table_q[i];
        return v;
    endfunction

    function longint scan_last(longint n, longint key);
        longint hit;
        hit = -1;
        for (longint i = 0; i < n; i++)
        begin
            if (entry(i) == key)
                hit = i;
        end
        return hit;
    endfunction

    function longint halve(longint n, longint key);
        longint lo, hi, mid, v;
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            v = entry(mid);
            if (v == key)
                return mid;
            if (v < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function longint probe(longint n, longint key);
        longint lo, hi, mid, v, vlo, vhi;
        lo = 0;
        hi = n - 1;
        while (lo <= hi)
        begin
            vlo = entry(lo);
            vhi = entry(hi);
            if (key < vlo || key > vhi)
                break;
            if (vhi == vlo)
                mid = lo;
            else
                mid = lo + ((key - vlo) * (hi - lo)) / (vhi - vlo);
            v = entry(mid);
            if (v == key)
                return mid;
            if (v < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function void note(srts_pkg::req_t r);
        longint n, key, pos;
        srts_pkg::rsp_t e;
        if (r.req_type == srts_pkg::REQ_WRITE)
        begin
            table_q[r.entry_index] = r.entry_value;
            return;
        end
        n = (count > 1024) ? 1024 : count;
        key = r.search_key;
        case (mode)
            srts_pkg::MODE_LINEAR: pos = scan_last(n, key);
            srts_pkg::MODE_BINARY: pos = halve(n, key);
            srts_pkg::MODE_INTERP: pos = probe(n, key);
            default:               pos = -1;
        endcase
        e.found = (pos >= 0);
        e.position = (pos >= 0) ? pos[9:0] : 10'd0;
        expected_q.push_back(e);
        searches++;
    endfunction

    function void check(srts_pkg::rsp_t r);
        srts_pkg::rsp_t e;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response found=%0d position=%0d", r.found, r.position);
            return;
        end
        e = expected_q.pop_front();
        if (r.found !== e.found || r.position !== e.position)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                         e.found, e.position, r.found, r.position);
        end
    endfunction
endclass

module tb_sorted_table_search_top;
    import srts_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_MODE;
    logic [10:0] cfg_wdata = '0;

    search_scoreboard sb = new();
    bit idle_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int random_reqs = 0;
    int phases = 0;

    sorted_table_search_top i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check(rsp);
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 200000)
        begin
            $display("watchdog expired, %0d responses outstanding", sb.expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note(r);
    endtask

    task automatic put_entry(input int idx, input logic signed [31:0] v);
        req_t r;
        r = '0;
        r.req_type = REQ_WRITE;
        r.entry_index = idx;
        r.entry_value = v;
        r.search_key = $urandom;
        send(r);
    endtask

    task automatic look_up(input logic signed [31:0] key);
        req_t r;
        r.req_type = REQ_SEARCH;
        r.entry_index = $urandom;
        r.entry_value = $urandom;
        r.search_key = key;
        send(r);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] m, input int unsigned n);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_wdata <= {9'd0, m};
        @(posedge clk);
        cfg_index <= CFG_COUNT;
        cfg_wdata <= n[10:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
        sb.count = n;
    endtask

    // ascending run with occasional duplicates
    task automatic fill_sorted(input int first, input int n, input longint start,
                               input longint step);
        longint v;
        v = start;
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && first + n == 1024)
                v = 64'sd2147483647;
            put_entry(first + i, v[31:0]);
            if ($urandom_range(0, 5) != 0)
                v += $urandom_range(1, step);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
        end
    endtask

    task automatic random_item(input int n);
        longint lo, hi, v;
        int idx;
        if ($urandom_range(0, 3) == 0)
        begin
            idx = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, 63);
            if ($urandom_range(0, 6) == 0)
                v = $signed($urandom);
            else
            begin
                lo = (idx > 0) ? sb.entry(idx - 1) : -64'sd2147483648;
                hi = (idx < 63) ? sb.entry(idx + 1) : 64'sd2147483647;
                if (hi < lo)
                    v = lo;
                else
                    v = lo + ({$urandom, $urandom} % (hi - lo + 1));
            end
            put_entry(idx, v[31:0]);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0, 1, 2: v = (n > 0) ? sb.entry($urandom_range(0, n - 1)) : $signed($urandom);
                3:       v = (n > 0) ? sb.entry($urandom_range(0, n - 1)) + 1 : 0;
                default: v = $signed($urandom);
            endcase
            look_up(v[31:0]);
        end
    endtask

    initial
    begin
        logic [1:0] m;
        int unsigned n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(MODE_LINEAR, 0);
        look_up(32'sd0);
        fill_sorted(0, 64, -64'sd2147483648, 60000000);
        put_entry(511, 32'sd7);
        put_entry(1023, 32'sd2147483647);
        for (int md = 0; md < 4; md++)
        begin
            configure(md[1:0], 64);
            look_up(sb.table_q[0]);
            look_up(sb.table_q[63]);
            look_up(sb.table_q[37]);
            look_up(sb.table_q[30] + 32'sd1);
        end
        // oversized counts probe only entries that were written
        configure(MODE_BINARY, 2047);
        look_up(sb.table_q[511]);
        configure(MODE_INTERP, 1500);
        look_up(sb.table_q[0]);
        configure(MODE_INTERP, 1);
        look_up(sb.table_q[0]);
        look_up(sb.table_q[0] + 32'sd1);
        configure(MODE_LINEAR, 0);
        look_up(sb.table_q[0]);

        while (random_reqs < 490)
        begin
            phases++;
            m = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0:       n = 64;
                1:       n = 0;
                default: n = $urandom_range(1, 64);
            endcase
            configure(m, n);
            if ($urandom_range(0, 1) == 0)
            begin
                fill_sorted(0, n, $signed($urandom) / 2, $urandom_range(1, 1000));
                random_reqs += n;
            end
            for (int k = 0; k < 30; k++)
            begin
                if (random_reqs > 420)
                    idle_on = 1'b0;
                random_item(n);
                random_reqs++;
            end
        end

        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d searches over %0d configuration phases in all four modes,",
                 sb.searches, phases);
        $display("empty and oversized counts, duplicates and unsorted entries");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sorted_table_search_top.f =====
hdl/srts_pkg.sv
hdl/srts_ram.sv
hdl/srts_div.sv
hdl/sorted_table_search_top.sv
sim/tb_sorted_table_search_top.sv
